// File: rtl/bgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_pkg
// Types and constants shared by the button gesture detector files.
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int unsigned TimeBitsDefault = 16;
  localparam int unsigned CfgTimeW        = 16;
  localparam int unsigned DebounceW       = 8;
  localparam int unsigned ApbAddrW        = 4;
  localparam int unsigned ApbDataW        = 32;

  localparam logic                 ActiveLowRst     = 1'b1;
  localparam logic [DebounceW-1:0] DebounceRst      = 8'd10;
  localparam logic [CfgTimeW-1:0]  LongPressRst     = 16'd1000;
  localparam logic [CfgTimeW-1:0]  DoubleClickRst   = 16'd300;
  localparam logic [DebounceW-1:0] SteadyMax        = 8'hFF;
  localparam logic [1:0]           ClickMax         = 2'd2;

  typedef enum logic [1:0] {
    GestNone   = 2'd0,
    GestSingle = 2'd1,
    GestDouble = 2'd2,
    GestLong   = 2'd3
  } gesture_e;

  typedef enum logic [1:0] {
    RegActiveLow   = 2'd0,
    RegDebounce    = 2'd1,
    RegLongPress   = 2'd2,
    RegDoubleClick = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                 active_low;
    logic [DebounceW-1:0] debounce_ms;
    logic [CfgTimeW-1:0]  long_press_ms;
    logic [CfgTimeW-1:0]  double_click_ms;
  } cfg_t;

endpackage

// File: rtl/bgd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_in_if / bgd_out_if
// Valid/ready channels for tick items and gesture results.
// ----------------------------------------------------------------------------
interface bgd_in_if;
  logic valid;
  logic ready;
  logic raw_level;

  modport source (output valid, output raw_level, input ready);
  modport sink   (input valid, input raw_level, output ready);
endinterface

interface bgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;
  logic       is_pressed;

  modport source (output valid, output gesture, output is_pressed, input ready);
  modport sink   (input valid, input gesture, input is_pressed, output ready);
endinterface

// File: rtl/bgd_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_cfg_regs
// APB register file holding polarity, debounce and gesture timing settings.
// ----------------------------------------------------------------------------
module bgd_cfg_regs import bgd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegActiveLow:   cfg_d.active_low      = pwdata[0];
        RegDebounce:    cfg_d.debounce_ms     = pwdata[DebounceW-1:0];
        RegLongPress:   cfg_d.long_press_ms   = pwdata[CfgTimeW-1:0];
        RegDoubleClick: cfg_d.double_click_ms = pwdata[CfgTimeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegActiveLow:   prdata = {{(ApbDataW-1){1'b0}}, cfg_q.active_low};
      RegDebounce:    prdata = {{(ApbDataW-DebounceW){1'b0}}, cfg_q.debounce_ms};
      RegLongPress:   prdata = {{(ApbDataW-CfgTimeW){1'b0}}, cfg_q.long_press_ms};
      RegDoubleClick: prdata = {{(ApbDataW-CfgTimeW){1'b0}}, cfg_q.double_click_ms};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low      <= ActiveLowRst;
      cfg_q.debounce_ms     <= DebounceRst;
      cfg_q.long_press_ms   <= LongPressRst;
      cfg_q.double_click_ms <= DoubleClickRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/bgd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bgd_core
// Input register, debounce / hold / click update, and result register.
// ----------------------------------------------------------------------------
module bgd_core import bgd_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       raw_level_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] gesture_o,
  output logic       is_pressed_o
);

  localparam int unsigned CmpW = (TIME_BITS > CfgTimeW) ? TIME_BITS : CfgTimeW;
  localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

  // pipeline control
  logic in_v_q, raw_q;
  logic out_v_q;
  gesture_e gest_q, gest_d;
  logic     press_q;
  logic     out_load, s1_adv;

  // detector state
  logic                 stable_q, stable_d;
  logic                 last_q, last_d;
  logic [DebounceW-1:0] steady_q, steady_d;
  logic [TIME_BITS-1:0] held_q, held_d;
  logic                 long_q, long_d;
  logic [1:0]           click_q, click_d;
  logic [TIME_BITS-1:0] rel_q, rel_d;

  logic                 level, press_edge, release_edge, long_base;
  logic [DebounceW-1:0] need;

  assign out_load   = !out_v_q || out_ready_i;
  assign s1_adv     = in_v_q && out_load;
  assign in_ready_o = !in_v_q || out_load;

  always_comb begin
    level        = raw_q ^ cfg_i.active_low;
    need         = (cfg_i.debounce_ms == '0) ? DebounceW'(1) : cfg_i.debounce_ms;
    press_edge   = 1'b0;
    release_edge = 1'b0;
    gest_d       = GestNone;
    stable_d     = stable_q;
    held_d       = held_q;
    click_d      = click_q;
    rel_d        = rel_q;

    // debounce
    if (level == last_q) begin
      last_d   = last_q;
      steady_d = (steady_q == SteadyMax) ? steady_q : steady_q + DebounceW'(1);
    end else begin
      last_d   = level;
      steady_d = DebounceW'(1);
    end
    if (steady_d >= need && last_d != stable_q) begin
      stable_d     = last_d;
      press_edge   = last_d;
      release_edge = !last_d;
    end

    // hold timing and long press
    if (press_edge) begin
      held_d = '0;
    end else if (stable_d) begin
      held_d = (held_q == TimeMax) ? held_q : held_q + TIME_BITS'(1);
    end
    long_base = press_edge ? 1'b0 : long_q;
    long_d    = long_base;
    if (stable_d && !long_base &&
        CmpW'(held_d) >= CmpW'(cfg_i.long_press_ms)) begin
      long_d  = 1'b1;
      click_d = '0;
      gest_d  = GestLong;
    end

    // release timing and click report
    if (release_edge && !long_d) begin
      click_d = (click_q == ClickMax) ? click_q : click_q + 2'd1;
      rel_d   = '0;
    end else if (!stable_d) begin
      rel_d = (rel_q == TimeMax) ? rel_q : rel_q + TIME_BITS'(1);
    end
    if (!stable_d && click_d != '0 &&
        CmpW'(rel_d) >= CmpW'(cfg_i.double_click_ms)) begin
      gest_d  = (click_d == 2'd1) ? GestSingle : GestDouble;
      click_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
      stable_q <= 1'b0;
      last_q   <= 1'b0;
      steady_q <= '0;
      held_q   <= '0;
      long_q   <= 1'b0;
      click_q  <= '0;
      rel_q    <= '0;
    end else begin
      if (in_ready_o) begin
        in_v_q <= in_valid_i;
      end
      if (out_load) begin
        out_v_q <= in_v_q;
      end
      // commit state only when the item moves into the result register
      if (s1_adv) begin
        stable_q <= stable_d;
        last_q   <= last_d;
        steady_q <= steady_d;
        held_q   <= held_d;
        long_q   <= long_d;
        click_q  <= click_d;
        rel_q    <= rel_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      raw_q <= raw_level_i;
    end
    if (s1_adv) begin
      gest_q  <= gest_d;
      press_q <= stable_d;
    end
  end

  assign out_valid_o  = out_v_q;
  assign gesture_o    = gest_q;
  assign is_pressed_o = press_q;

endmodule

// File: rtl/button_gesture_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_gesture_detector_unit
// Single click, double click and long press detection for one push button.
// ----------------------------------------------------------------------------
// Each input item is one millisecond tick carrying the raw pin level; each
// item yields exactly one result with the gesture (none, single click, double
// click, long press start) and the debounced pressed state after that tick.
// An item passes through the input register, then the result register, and
// a new item is accepted every cycle unless a held result stalls the output;
// the state update between the two registers is combinational. Program the
// APB registers only while no items are in flight.
// Registers at byte addresses 0x0 active_low, 0x4 debounce_ms,
// 0x8 long_press_ms, 0xC double_click_ms.
// ----------------------------------------------------------------------------
module button_gesture_detector_unit import bgd_pkg::*; #(
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bgd_in_if.sink              in_i,
  bgd_out_if.source           out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t cfg;

  bgd_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bgd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .raw_level_i  (in_i.raw_level),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .gesture_o    (out_o.gesture),
    .is_pressed_o (out_o.is_pressed)
  );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for button_gesture_detector_unit.
// ----------------------------------------------------------------------------
// Drives one tick item per raw button sample and predicts the gesture and
// debounced pressed state of every tick with an internal copy of the detector
// state. Register values are written over APB between phases and read back
// in the register access test. Stimulus covers directed corner cases, extreme
// register settings with a saturating steady count, and random click/hold
// sequences with bounce; most phases run under random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
  import bgd_pkg::*;

  localparam int unsigned TimeBits   = TimeBitsDefault;
  localparam int          StallLimit = 2000;

  typedef struct packed {
    gesture_e gesture;
    logic     pressed;
  } tick_result_t;

  typedef struct {
    logic                 stable;
    logic                 last_lvl;
    logic [DebounceW-1:0] steady;
    logic [TimeBits-1:0]  held;
    logic                 long_on;
    logic [1:0]           clicks;
    logic [TimeBits-1:0]  released;
  } button_state_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  bgd_in_if  tick_if ();
  bgd_out_if gest_if ();

  button_gesture_detector_unit #(
    .TIME_BITS(TimeBits)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_if),
    .out_o  (gest_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  cfg_t          cfg;
  button_state_t btn;
  tick_result_t  expected_results[$];
  tick_result_t  want;

  int   errors        = 0;
  int   ticks_sent    = 0;
  int   results_seen  = 0;
  int   config_phases = 0;
  int   stall_cycles  = 0;
  int   src_idle_pct  = 0;
  int   sink_idle_pct = 0;
  int   seen_kind[4]  = '{0, 0, 0, 0};

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $time, msg);
    errors++;
  endtask

  // Advance the detector by one tick and return its result.
  function automatic void advance_tick(input logic raw, output gesture_e gest,
                                       output logic pressed);
    logic                 lvl;
    logic [DebounceW-1:0] need;
    logic                 press_edge;
    logic                 release_edge;
    lvl          = cfg.active_low ? ~raw : raw;
    need         = (cfg.debounce_ms == '0) ? DebounceW'(1) : cfg.debounce_ms;
    press_edge   = 1'b0;
    release_edge = 1'b0;
    gest         = GestNone;

    if (lvl == btn.last_lvl) begin
      if (btn.steady != SteadyMax) btn.steady++;
    end else begin
      btn.last_lvl = lvl;
      btn.steady   = DebounceW'(1);
    end
    if (btn.steady >= need && btn.last_lvl != btn.stable) begin
      btn.stable = btn.last_lvl;
      if (btn.stable) press_edge = 1'b1;
      else release_edge = 1'b1;
    end

    if (press_edge) begin
      btn.held    = '0;
      btn.long_on = 1'b0;
    end else if (btn.stable && btn.held != '1) begin
      btn.held++;
    end
    if (btn.stable && !btn.long_on && btn.held >= cfg.long_press_ms) begin
      btn.long_on = 1'b1;
      btn.clicks  = 2'd0;
      gest        = GestLong;
    end

    // a release that ends a long press counts no click
    if (release_edge && !btn.long_on) begin
      if (btn.clicks < ClickMax) btn.clicks++;
      btn.released = '0;
    end else if (!btn.stable && btn.released != '1) begin
      btn.released++;
    end
    if (!btn.stable && btn.clicks != 2'd0 && btn.released >= cfg.double_click_ms) begin
      gest       = (btn.clicks == 2'd1) ? GestSingle : GestDouble;
      btn.clicks = 2'd0;
    end
    pressed = btn.stable;
  endfunction

  task automatic send_tick(input logic raw);
    tick_result_t r;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    tick_if.valid     <= 1'b1;
    tick_if.raw_level <= raw;
    do @(posedge clk_i); while (!tick_if.ready);
    advance_tick(raw, r.gesture, r.pressed);
    expected_results.push_back(r);
    ticks_sent++;
  endtask

  // Hold the button in one state for n ticks.
  task automatic send_level(input logic pressed, input int n);
    repeat (n) send_tick(pressed ^ cfg.active_low);
  endtask

  task automatic send_bounce();
    repeat ($urandom_range(0, 3)) send_tick(1'($urandom_range(0, 1)));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    tick_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [ApbDataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(int'(idx) * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      RegActiveLow:   cfg.active_low      = val[0];
      RegDebounce:    cfg.debounce_ms     = val[DebounceW-1:0];
      RegLongPress:   cfg.long_press_ms   = val[CfgTimeW-1:0];
      RegDoubleClick: cfg.double_click_ms = val[CfgTimeW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input reg_idx_e idx);
    logic [ApbDataW-1:0] expect_val;
    case (idx)
      RegActiveLow:   expect_val = ApbDataW'(cfg.active_low);
      RegDebounce:    expect_val = ApbDataW'(cfg.debounce_ms);
      RegLongPress:   expect_val = ApbDataW'(cfg.long_press_ms);
      default:        expect_val = ApbDataW'(cfg.double_click_ms);
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(int'(idx) * 4);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== expect_val)
      report_mismatch($sformatf("register %s reads 0x%0h, want 0x%0h",
                                idx.name(), prdata, expect_val));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic al, input int deb, input int lp, input int dc);
    wait_drained();
    apb_write(RegActiveLow, ApbDataW'(al));
    apb_write(RegDebounce, ApbDataW'(deb));
    apb_write(RegLongPress, ApbDataW'(lp));
    apb_write(RegDoubleClick, ApbDataW'(dc));
    config_phases++;
  endtask

  task automatic test_register_access();
    apb_read_check(RegActiveLow);
    apb_read_check(RegDebounce);
    apb_read_check(RegLongPress);
    apb_read_check(RegDoubleClick);
    set_config(1'b0, 255, 65535, 65535);
    apb_read_check(RegActiveLow);
    apb_read_check(RegDebounce);
    apb_read_check(RegLongPress);
    apb_read_check(RegDoubleClick);
    set_config(1'b1, 0, 0, 0);
    apb_read_check(RegActiveLow);
    apb_read_check(RegDebounce);
    apb_read_check(RegLongPress);
    apb_read_check(RegDoubleClick);
  endtask

  task automatic test_directed();
    // zero debounce, long press and double-click times, active high
    set_config(1'b0, 0, 0, 0);
    send_tick(1'b1);   // long press start on the press edge
    send_tick(1'b0);   // release after long press: no click
    set_config(1'b0, 1, 4, 0);
    send_level(1'b1, 2);
    send_level(1'b0, 1);   // single click on the release tick
    // active low with bounce restarting the debounce count
    set_config(1'b1, 3, 6, 5);
    send_tick(1'b0);
    send_tick(1'b1);
    send_level(1'b1, 3);
    send_level(1'b0, 8);
    send_level(1'b1, 3);
    send_level(1'b0, 3);
    send_level(1'b1, 3);
    send_level(1'b0, 9);
    // a long press discards the pending click
    set_config(1'b1, 1, 4, 20);
    send_level(1'b1, 1);
    send_level(1'b0, 1);
    send_level(1'b1, 6);
    send_level(1'b0, 22);
  endtask

  // Largest debounce with the longest hold and double-click times; the steady
  // count runs into saturation.
  task automatic test_extremes();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_config(1'b0, 255, 65535, 65535);
    send_level(1'b1, 255 + 3);
    send_level(1'b0, 255 + 3);
  endtask

  task automatic test_random_gestures(input int n_items, input int src_pct, input int sink_pct);
    int stop_at;
    int reconf_at;
    int kind;
    int clicks;
    int deb;
    int lp;
    int lp_cap;
    int dc;
    int hold;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    stop_at       = ticks_sent + n_items;
    reconf_at     = ticks_sent;
    while (ticks_sent < stop_at) begin
      if (ticks_sent >= reconf_at) begin
        deb = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
        lp  = ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 30);
        dc  = $urandom_range(0, 25);
        set_config(1'($urandom_range(0, 1)), deb, lp, dc);
        reconf_at = ticks_sent + $urandom_range(80, 160);
      end
      lp_cap = (lp > 60) ? 60 : lp;
      kind   = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)));
      end else begin
        clicks = (kind >= 4 && kind <= 6) ? $urandom_range(2, 3) : 1;
        for (int c = 0; c < clicks; c++) begin
          if (kind >= 7) hold = lp_cap + deb + $urandom_range(0, 10);
          else hold = $urandom_range(1, lp_cap + deb + 3);
          send_bounce();
          send_level(1'b1, hold);
          send_bounce();
          if (c == clicks - 1) send_level(1'b0, dc + deb + $urandom_range(1, 6));
          else send_level(1'b0, $urandom_range(1, dc / 2 + deb + 2));
        end
      end
    end
  endtask

  // Drop ready at random at the receiver's idle rate.
  always @(negedge clk_i) begin
    gest_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && gest_if.valid && gest_if.ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch("result with no tick pending");
      end else begin
        want = expected_results.pop_front();
        seen_kind[int'(want.gesture)]++;
        if (gest_if.gesture !== want.gesture)
          report_mismatch($sformatf("result %0d: gesture %0d, want %0d",
                                    results_seen, gest_if.gesture, want.gesture));
        if (gest_if.is_pressed !== want.pressed)
          report_mismatch($sformatf("result %0d: is_pressed %0b, want %0b",
                                    results_seen, gest_if.is_pressed, want.pressed));
      end
    end
  end

  initial begin
    while (stall_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((tick_if.valid && tick_if.ready) || (gest_if.valid && gest_if.ready) ||
          (psel && penable))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results pending",
             StallLimit, expected_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_ni            = 1'b0;
    tick_if.valid     = 1'b0;
    tick_if.raw_level = 1'b0;
    gest_if.ready     = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cfg               = '{ActiveLowRst, DebounceRst, LongPressRst, DoubleClickRst};
    btn               = '{1'b0, 1'b0, '0, '0, 1'b0, 2'd0, '0};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    src_idle_pct  = 19;
    sink_idle_pct = 53;
    test_register_access();
    test_directed();
    test_extremes();
    test_random_gestures(160, 19, 53);
    test_random_gestures(160, 53, 19);
    test_random_gestures(160, 0, 0);
    wait_drained();

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    $display("Sent %0d ticks over %0d register settings, %0d results checked.",
             ticks_sent, config_phases, results_seen);
    $display("Gestures: %0d single, %0d double, %0d long press starts; %0d errors.",
             seen_kind[1], seen_kind[2], seen_kind[3], errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/bgd_pkg.sv
rtl/bgd_if.sv
rtl/bgd_cfg_regs.sv
rtl/bgd_core.sv
rtl/button_gesture_detector_unit.sv
sim/tb.sv
